// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- src/ncc_pkg.sv -----
// Package with constants and types of the NCC stereo disparity block.
`default_nettype none
package ncc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_DISP   = 128;
    localparam int MAX_BLOCK  = 15;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int SLOT_W   = $clog2(MAX_BLOCK);
    localparam int ADDR_W   = SLOT_W + COL_W;
    localparam int MEM_DEPTH = MAX_BLOCK * MAX_WIDTH;
    localparam int DISP_W   = 7;
    localparam int PIX_W    = 8;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_RADIUS_W = 3;
    localparam int CFG_COUNT_W  = 8;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;

    localparam int SUM_W   = 16;
    localparam int SUMSQ_W = 24;
    localparam int N_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_BLOCK_RADIUS    = 2'd1,
        CFG_DISPARITY_COUNT = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic               first;
        logic [DISP_W-1:0]  disp;
        logic [N_W-1:0]     n;
        logic [SUM_W-1:0]   sum_l;
        logic [SUMSQ_W-1:0] sum_ll;
        logic [SUM_W-1:0]   sum_r;
        logic [SUMSQ_W-1:0] sum_rr;
        logic [SUMSQ_W-1:0] sum_lr;
    } t_score_req;

    typedef struct packed {
        logic              busy;
        logic [DISP_W-1:0] best_d;
    } t_score_rsp;

endpackage
`default_nettype wire

// ----- src/ncc_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ncc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/ncc_score.sv -----
// Score unit: one shared 32x32 multiplier sequenced over the NCC terms and compare.
`default_nettype none
module ncc_score (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ncc_pkg::t_score_req i_req,
    output ncc_pkg::t_score_rsp    o_rsp
);
    import ncc_pkg::*;

    typedef enum logic [3:0] {
        ST_NLL, ST_LL, ST_NRR, ST_RR, ST_NLR, ST_LR, ST_SQ,
        ST_P1L, ST_P1H, ST_P2L, ST_P2H, ST_CMP
    } t_step;

    typedef enum logic [1:0] {
        SG_NEG  = 2'd0,
        SG_ZERO = 2'd1,
        SG_POS  = 2'd2
    } t_sign;

    t_step              r_step;
    logic               r_busy;
    logic               r_phase;
    logic               r_first;
    logic [DISP_W-1:0]  r_disp;
    logic [N_W-1:0]     r_n;
    logic [SUM_W-1:0]   r_sl;
    logic [SUMSQ_W-1:0] r_sll;
    logic [SUM_W-1:0]   r_sr;
    logic [SUMSQ_W-1:0] r_srr;
    logic [SUMSQ_W-1:0] r_slr;
    logic [63:0]        r_prod;
    logic [63:0]        r_p0;
    logic               r_azero;
    logic [31:0]        r_b;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [63:0]        r_sq;
    logic [95:0]        r_p1;
    logic [95:0]        r_p2;
    logic [63:0]        r_best_sq;
    logic [31:0]        r_best_b;
    t_sign              r_best_sign;
    logic [DISP_W-1:0]  r_best_d;

    logic [31:0] w_op_x;
    logic [31:0] w_op_y;
    t_sign       w_sign;
    logic        w_gt;

    always_comb begin
        w_op_x = '0;
        w_op_y = '0;
        case (r_step)
            ST_NLL: begin w_op_x = 32'(r_n);  w_op_y = 32'(r_sll); end
            ST_LL:  begin w_op_x = 32'(r_sl); w_op_y = 32'(r_sl);  end
            ST_NRR: begin w_op_x = 32'(r_n);  w_op_y = 32'(r_srr); end
            ST_RR:  begin w_op_x = 32'(r_sr); w_op_y = 32'(r_sr);  end
            ST_NLR: begin w_op_x = 32'(r_n);  w_op_y = 32'(r_slr); end
            ST_LR:  begin w_op_x = 32'(r_sl); w_op_y = 32'(r_sr);  end
            ST_SQ:  begin w_op_x = r_mag;     w_op_y = r_mag;      end
            ST_P1L: begin w_op_x = r_sq[31:0];  w_op_y = r_best_b; end
            ST_P1H: begin w_op_x = r_sq[63:32]; w_op_y = r_best_b; end
            ST_P2L: begin w_op_x = r_best_sq[31:0];  w_op_y = r_b; end
            ST_P2H: begin w_op_x = r_best_sq[63:32]; w_op_y = r_b; end
            default: begin w_op_x = '0; w_op_y = '0; end
        endcase
    end

    // A zero right-side variance makes the score zero.
    always_comb begin
        if (r_b == '0) begin
            w_sign = SG_ZERO;
        end else if (r_neg) begin
            w_sign = SG_NEG;
        end else if (r_mag == '0) begin
            w_sign = SG_ZERO;
        end else begin
            w_sign = SG_POS;
        end
    end

    // The left variance is common to all disparities, so it drops out of the
    // cross products; a zero left variance makes every score zero.
    always_comb begin
        if (r_azero) begin
            w_gt = 1'b0;
        end else if (w_sign != r_best_sign) begin
            w_gt = (w_sign > r_best_sign);
        end else if (w_sign == SG_ZERO) begin
            w_gt = 1'b0;
        end else if (w_sign == SG_POS) begin
            w_gt = (r_p1 > r_p2);
        end else begin
            w_gt = (r_p1 < r_p2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= 1'b0;
            r_step   <= ST_NLL;
            r_best_d <= '0;
        end else if (!r_busy) begin
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_first <= i_req.first;
                r_disp  <= i_req.disp;
                r_n     <= i_req.n;
                r_sl    <= i_req.sum_l;
                r_sll   <= i_req.sum_ll;
                r_sr    <= i_req.sum_r;
                r_srr   <= i_req.sum_rr;
                r_slr   <= i_req.sum_lr;
                r_step  <= i_req.first ? ST_NLL : ST_NRR;
            end
        end else if (r_step == ST_CMP) begin
            if (w_gt) begin
                r_best_d    <= r_disp;
                r_best_sq   <= r_sq;
                r_best_b    <= r_b;
                r_best_sign <= w_sign;
            end
            r_busy <= 1'b0;
        end else if (!r_phase) begin
            r_prod  <= w_op_x * w_op_y;
            r_phase <= 1'b1;
        end else begin
            r_phase <= 1'b0;
            case (r_step)
                ST_NLL: begin
                    r_p0   <= r_prod;
                    r_step <= ST_LL;
                end
                ST_LL: begin
                    r_azero <= (r_p0 == r_prod);
                    r_step  <= ST_NRR;
                end
                ST_NRR: begin
                    r_p0   <= r_prod;
                    r_step <= ST_RR;
                end
                ST_RR: begin
                    r_b    <= 32'(r_p0 - r_prod);
                    r_step <= ST_NLR;
                end
                ST_NLR: begin
                    r_p0   <= r_prod;
                    r_step <= ST_LR;
                end
                ST_LR: begin
                    if (r_p0 >= r_prod) begin
                        r_neg <= 1'b0;
                        r_mag <= 32'(r_p0 - r_prod);
                    end else begin
                        r_neg <= 1'b1;
                        r_mag <= 32'(r_prod - r_p0);
                    end
                    r_step <= ST_SQ;
                end
                ST_SQ: begin
                    r_sq <= r_prod;
                    if (r_first) begin
                        // Disparity zero is always the first best.
                        r_best_d    <= r_disp;
                        r_best_sq   <= r_prod;
                        r_best_b    <= r_b;
                        r_best_sign <= w_sign;
                        r_busy      <= 1'b0;
                    end else begin
                        r_step <= ST_P1L;
                    end
                end
                ST_P1L: begin
                    r_p1   <= {32'b0, r_prod};
                    r_step <= ST_P1H;
                end
                ST_P1H: begin
                    r_p1   <= r_p1 + {r_prod, 32'b0};
                    r_step <= ST_P2L;
                end
                ST_P2L: begin
                    r_p2   <= {32'b0, r_prod};
                    r_step <= ST_P2H;
                end
                ST_P2H: begin
                    r_p2   <= r_p2 + {r_prod, 32'b0};
                    r_step <= ST_CMP;
                end
                default: begin
                    r_step <= ST_CMP;
                end
            endcase
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.best_d = r_best_d;
endmodule
`default_nettype wire

// ----- src/ncc_stereo_disparity.sv -----
// Top level of the NCC stereo disparity block: line stores, window sweep, output.
`default_nettype none
`include "assert_macros.svh"
// Stereo disparity by normalized cross-correlation. Left and right pixels
// arrive together in raster order, one pair per transfer on the slave side;
// tuser marks the first pixel of a frame. Each pixel is written into two line
// stores of MAX_BLOCK rows. Once a full window of side 2r+1 round a centre
// pixel is present (column and row both at least 2r), the block scores
// disparities 0 to count-1 and sends the best one, with the centre column
// and row, as one transfer on the master side; ties keep the smaller
// disparity. Border pixels are never sent. A pixel that yields no result
// does not hold the slave side off. A pixel that yields a result holds it
// off until the result is in the output register. The window sweep reads
// one tap per cycle through the single read port of each line store, and
// the score of one disparity (nine 32x32 multiplies on one shared
// multiplier, seven for disparity zero, then a compare) overlaps the sweep
// of the next. A finished result waits in the output register while the
// next pixel is taken. The line stores are not cleared; they are only read
// where written.
module ncc_stereo_disparity (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [ncc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ncc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [7:0] left_pixel, [15:8] right_pixel
    input  wire logic        s_axis_tuser,  // [0] frame_start
    // disparity output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // [6:0] disparity, [16:7] out_x,
                                            // [26:17] out_y, [31:27] zero
);
    import ncc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SWEEP, S_DRAIN, S_KICK, S_FINISH
    } t_state;

    t_state r_state;

    // configuration
    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_RADIUS_W-1:0] r_cfg_radius;
    logic [CFG_COUNT_W-1:0]  r_cfg_count;

    logic [CFG_WIDTH_W-1:0]  w_width;
    logic [CFG_RADIUS_W-1:0] w_radius;
    logic [CFG_COUNT_W-1:0]  w_count;
    logic [SLOT_W-1:0]       w_two_r;
    logic [SLOT_W-1:0]       w_side;

    // raster position
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_slot;

    logic              w_acc;
    logic [COL_W-1:0]  w_x;
    logic [ROW_W-1:0]  w_y;
    logic [SLOT_W-1:0] w_slot;
    logic [COL_W:0]    w_x1;
    logic              w_emit;
    logic [SLOT_W:0]   w_start_tmp;
    logic [SLOT_W-1:0] w_start_slot;

    // sweep of one pixel
    logic [COL_W-1:0]   r_x0;
    logic [COL_W-1:0]   r_cx;
    logic [ROW_W-1:0]   r_cy;
    logic [SLOT_W-1:0]  r_slot0;
    logic [SLOT_W-1:0]  r_slot_i;
    logic [SLOT_W-1:0]  r_i;
    logic [SLOT_W-1:0]  r_j;
    logic [SLOT_W-1:0]  r_side;
    logic [N_W-1:0]     r_n;
    logic [DISP_W-1:0]  r_d;
    logic [CFG_COUNT_W-1:0] r_count;

    logic [COL_W-1:0]   w_col_l;
    logic [COL_W+1:0]   w_col_r;
    logic [ADDR_W-1:0]  w_raddr_l;
    logic [ADDR_W-1:0]  w_raddr_r;
    logic [ADDR_W-1:0]  w_waddr;
    logic               w_last_d;

    // read pipeline and window sums
    logic               r_rd_vld;
    logic               r_rd_rz;
    logic               r_rd_d0;
    logic [PIX_W-1:0]   w_ldata;
    logic [PIX_W-1:0]   w_rdata;
    logic [PIX_W-1:0]   w_rv;
    logic [SUM_W-1:0]   r_sum_l;
    logic [SUMSQ_W-1:0] r_sum_ll;
    logic [SUM_W-1:0]   r_sum_r;
    logic [SUMSQ_W-1:0] r_sum_rr;
    logic [SUMSQ_W-1:0] r_sum_lr;

    t_score_req w_req;
    t_score_rsp w_rsp;

    logic        r_out_valid;
    logic [31:0] r_out_data;

    // Saturate the registers to the supported ranges.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_width = CFG_WIDTH_W'(1);
        end else if (r_cfg_width > CFG_WIDTH_W'(MAX_WIDTH)) begin
            w_width = CFG_WIDTH_W'(MAX_WIDTH);
        end else begin
            w_width = r_cfg_width;
        end
        w_radius = (r_cfg_radius == '0) ? CFG_RADIUS_W'(1) : r_cfg_radius;
        if (r_cfg_count == '0) begin
            w_count = CFG_COUNT_W'(1);
        end else if (r_cfg_count > CFG_COUNT_W'(MAX_DISP)) begin
            w_count = CFG_COUNT_W'(MAX_DISP);
        end else begin
            w_count = r_cfg_count;
        end
        w_two_r = {w_radius, 1'b0};
        w_side  = w_two_r + SLOT_W'(1);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // Position of the incoming pixel; frame start puts it at the origin.
    always_comb begin
        w_x    = s_axis_tuser ? '0 : r_col;
        w_y    = s_axis_tuser ? '0 : r_row;
        w_slot = s_axis_tuser ? '0 : r_slot;
        w_x1   = {1'b0, w_x} + (COL_W+1)'(1);
        w_emit = (w_x >= COL_W'(w_two_r)) && (w_y >= ROW_W'(w_two_r))
                 && ({1'b0, w_x} < w_width);
        // Slot of the top window row, y - 2r modulo MAX_BLOCK.
        w_start_tmp = {1'b0, w_slot} + (SLOT_W+1)'(MAX_BLOCK) - {1'b0, w_two_r};
        if (w_start_tmp >= (SLOT_W+1)'(MAX_BLOCK)) begin
            w_start_slot = SLOT_W'(w_start_tmp - (SLOT_W+1)'(MAX_BLOCK));
        end else begin
            w_start_slot = w_start_tmp[SLOT_W-1:0];
        end
    end

    // Tap addresses; a right column left of zero reads as zero.
    always_comb begin
        w_col_l   = r_x0 + COL_W'(r_j);
        w_col_r   = {2'b0, w_col_l} - (COL_W+2)'(r_d);
        w_raddr_l = {r_slot_i, w_col_l};
        w_raddr_r = {r_slot_i, w_col_r[COL_W-1:0]};
        w_waddr   = {w_slot, w_x};
        w_last_d  = ({1'b0, r_d} == r_count - CFG_COUNT_W'(1));
        w_rv      = r_rd_rz ? '0 : w_rdata;
    end

    ncc_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MEM_DEPTH)
    ) u_left_store (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[7:0]),
        .i_raddr (w_raddr_l),
        .o_rdata (w_ldata)
    );

    ncc_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MEM_DEPTH)
    ) u_right_store (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[15:8]),
        .i_raddr (w_raddr_r),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_req.start  = (r_state == S_KICK) && !w_rsp.busy;
        w_req.first  = (r_d == '0);
        w_req.disp   = r_d;
        w_req.n      = r_n;
        w_req.sum_l  = r_sum_l;
        w_req.sum_ll = r_sum_ll;
        w_req.sum_r  = r_sum_r;
        w_req.sum_rr = r_sum_rr;
        w_req.sum_lr = r_sum_lr;
    end

    ncc_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= CFG_WIDTH_W'(MAX_WIDTH);
            r_cfg_radius <= CFG_RADIUS_W'(5);
            r_cfg_count  <= CFG_COUNT_W'(MAX_DISP);
            r_col        <= '0;
            r_row        <= '0;
            r_slot       <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:     r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                    CFG_BLOCK_RADIUS:    r_cfg_radius <= i_cfg_data[CFG_RADIUS_W-1:0];
                    CFG_DISPARITY_COUNT: r_cfg_count  <= i_cfg_data[CFG_COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Drop the result once the master side takes it, unless a new
            // one is loaded in the same cycle.
            if (m_axis_tvalid && m_axis_tready
                && !(r_state == S_FINISH && !w_rsp.busy)) begin
                r_out_valid <= 1'b0;
            end

            // Accumulate the tap read in the previous cycle.
            r_rd_vld <= (r_state == S_SWEEP);
            r_rd_rz  <= w_col_r[COL_W+1];
            r_rd_d0  <= (r_d == '0);
            if (r_rd_vld) begin
                r_sum_r  <= r_sum_r + SUM_W'(w_rv);
                r_sum_rr <= r_sum_rr
                            + SUMSQ_W'({{PIX_W{1'b0}}, w_rv} * {{PIX_W{1'b0}}, w_rv});
                r_sum_lr <= r_sum_lr
                            + SUMSQ_W'({{PIX_W{1'b0}}, w_ldata} * {{PIX_W{1'b0}}, w_rv});
                if (r_rd_d0) begin
                    r_sum_l  <= r_sum_l + SUM_W'(w_ldata);
                    r_sum_ll <= r_sum_ll + SUMSQ_W'({{PIX_W{1'b0}}, w_ldata}
                                                    * {{PIX_W{1'b0}}, w_ldata});
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        // Advance the raster position; the row saturates.
                        if (w_x1 >= w_width) begin
                            r_col <= '0;
                            if (w_y < ROW_W'(MAX_HEIGHT - 1)) begin
                                r_row  <= w_y + ROW_W'(1);
                                r_slot <= (w_slot == SLOT_W'(MAX_BLOCK - 1))
                                          ? '0 : w_slot + SLOT_W'(1);
                            end else begin
                                r_row  <= w_y;
                                r_slot <= w_slot;
                            end
                        end else begin
                            r_col  <= w_x1[COL_W-1:0];
                            r_row  <= w_y;
                            r_slot <= w_slot;
                        end
                        if (w_emit) begin
                            r_x0     <= w_x - COL_W'(w_two_r);
                            r_cx     <= w_x - COL_W'(w_radius);
                            r_cy     <= w_y - ROW_W'(w_radius);
                            r_slot0  <= w_start_slot;
                            r_slot_i <= w_start_slot;
                            r_i      <= '0;
                            r_j      <= '0;
                            r_side   <= w_two_r;
                            r_n      <= N_W'(w_side) * N_W'(w_side);
                            r_d      <= '0;
                            r_count  <= w_count;
                            r_sum_l  <= '0;
                            r_sum_ll <= '0;
                            r_sum_r  <= '0;
                            r_sum_rr <= '0;
                            r_sum_lr <= '0;
                            r_state  <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_j == r_side) begin
                        r_j      <= '0;
                        r_i      <= r_i + SLOT_W'(1);
                        r_slot_i <= (r_slot_i == SLOT_W'(MAX_BLOCK - 1))
                                    ? '0 : r_slot_i + SLOT_W'(1);
                        if (r_i == r_side) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_j <= r_j + SLOT_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_KICK;
                end
                S_KICK: begin
                    // Hand the sums over, then sweep the next disparity or finish.
                    if (!w_rsp.busy) begin
                        if (w_last_d) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_d      <= r_d + DISP_W'(1);
                            r_i      <= '0;
                            r_j      <= '0;
                            r_slot_i <= r_slot0;
                            r_sum_r  <= '0;
                            r_sum_rr <= '0;
                            r_sum_lr <= '0;
                            r_state  <= S_SWEEP;
                        end
                    end
                end
                S_FINISH: begin
                    // Hold until the score is final and the output is free.
                    if (!w_rsp.busy && (!r_out_valid || m_axis_tready)) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {5'b0, r_cy, r_cx, w_rsp.best_d};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_IMPLIES(a_start_when_free, i_clk, i_rst_n, w_req.start, !w_rsp.busy)
    `ASSERT_IMPLIES(a_disp_in_range, i_clk, i_rst_n, r_state == S_SWEEP,
                    {1'b0, r_d} < r_count)
    `ASSERT_NEXT(a_emit_starts_at_zero, i_clk, i_rst_n, w_acc && w_emit,
                 r_state == S_SWEEP && r_d == '0)
endmodule
`default_nettype wire
